FILE: src/kcb_pkg.sv
`default_nettype none
package kcb_pkg;

  typedef enum logic [1:0] {
    OP_WRITE_KEY = 2'd0,
    OP_FRAME     = 2'd1,
    OP_FLAGGED   = 2'd2,
    OP_NONE      = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    CFG_LOOP_LENGTH    = 2'd0,
    CFG_COMPONENT_MASK = 2'd1,
    CFG_CROSSFADE      = 2'd2,
    CFG_HOLD           = 2'd3
  } cfg_e;

  // prim sits in the low bits so byte lanes 0..9 are prim, env, lod, lvl
  typedef struct packed {
    logic [7:0]  lvl;
    logic [7:0]  lod;
    logic [31:0] env;
    logic [31:0] prim;
  } color_t;

  typedef struct packed {
    logic [15:0] span;
    color_t      color;
  } key_t;

  typedef struct packed {
    opcode_e     opcode;
    logic [31:0] frame;
    logic        flag_active;
    logic [3:0]  key_index;
    logic [15:0] key_span;
    logic [31:0] key_primary;
    logic [31:0] key_environment;
    logic [7:0]  key_lod_fraction;
    logic [7:0]  key_min_level;
  } in_t;

  typedef struct packed {
    logic [31:0] out_primary;
    logic [31:0] out_environment;
    logic [7:0]  out_lod_fraction;
    logic [7:0]  out_min_level;
    logic        emit_primary;
    logic        emit_environment;
  } out_t;

  typedef struct packed {
    logic        start;
    logic [15:0] num;
    logic [15:0] den;
    logic [3:0]  mask;
  } lerp_req_t;

endpackage
`default_nettype wire

FILE: src/kcb_ram.sv
`default_nettype none
module kcb_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

FILE: src/kcb_lerp.sv
`default_nettype none
// Channel-serial blend: per enabled byte lane a multiply step, then 8 restoring
// divide steps. Lanes not selected by the mask keep the base value.
module kcb_lerp import kcb_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire lerp_req_t req_i,
  input  wire color_t    a_i,
  input  wire color_t    b_i,
  input  wire color_t    base_i,
  output      logic      done_o,
  output      color_t    res_o
);

  localparam int NumCh = 10;
  localparam logic [3:0] LastCh = 4'(NumCh - 1);

  typedef enum logic [1:0] {L_IDLE, L_MUL, L_DIV} lstate_e;

  lstate_e                state_q;
  logic [3:0]             ch_q;
  logic [2:0]             step_q;
  logic [24:0]            v_q;
  logic [7:0]             q_q;
  logic [NumCh-1:0][7:0]  res_q;
  logic                   done_q;

  logic [NumCh-1:0][7:0]  a_ch, b_ch;
  logic [15:0]            w_lo;
  logic [23:0]            p_a, p_b;
  logic [24:0]            prod, trial;
  logic                   ge, ch_en;
  logic [7:0]             q_n;

  assign a_ch = a_i;
  assign b_ch = b_i;
  assign w_lo = req_i.den - req_i.num;
  assign p_a  = a_ch[ch_q] * w_lo;
  assign p_b  = b_ch[ch_q] * req_i.num;
  assign prod = {1'b0, p_a} + {1'b0, p_b};
  assign trial = 25'({req_i.den, 7'b0}) >> (3'd7 - step_q);
  assign ge   = v_q >= trial;
  assign q_n  = ge ? (q_q | (8'd1 << step_q)) : q_q;

  // lod and level only follow when primary is enabled
  always_comb begin
    if (ch_q < 4'd4) begin
      ch_en = req_i.mask[0];
    end else if (ch_q < 4'd8) begin
      ch_en = req_i.mask[1];
    end else if (ch_q == 4'd8) begin
      ch_en = req_i.mask[0] & req_i.mask[2];
    end else begin
      ch_en = req_i.mask[0] & req_i.mask[3];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      ch_q    <= '0;
      step_q  <= '0;
      v_q     <= '0;
      q_q     <= '0;
      res_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        L_IDLE: begin
          if (req_i.start) begin
            res_q   <= base_i;
            ch_q    <= '0;
            state_q <= L_MUL;
          end
        end
        L_MUL: begin
          if (ch_en) begin
            v_q     <= prod;
            q_q     <= '0;
            step_q  <= 3'd7;
            state_q <= L_DIV;
          end else if (ch_q == LastCh) begin
            done_q  <= 1'b1;
            state_q <= L_IDLE;
          end else begin
            ch_q <= ch_q + 4'd1;
          end
        end
        L_DIV: begin
          v_q <= ge ? v_q - trial : v_q;
          q_q <= q_n;
          if (step_q == 3'd0) begin
            res_q[ch_q] <= q_n;
            if (ch_q == LastCh) begin
              done_q  <= 1'b1;
              state_q <= L_IDLE;
            end else begin
              ch_q    <= ch_q + 4'd1;
              state_q <= L_MUL;
            end
          end else begin
            step_q <= step_q - 3'd1;
          end
        end
        default: state_q <= L_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule
`default_nettype wire

FILE: src/keyframe_color_blender.sv
// Keyframe color blender.
// Input channel (in_valid_i/in_ready_o/in_data_i): key writes and frame items.
// A key write stores into the key table and gives no result.
// A frame item gives one result beat on out_valid_o/out_ready_i/out_data_o
// (a flagged item with the flag low, no fade and hold off gives none).
// A frame item takes frame mod loop_length in the serial remainder unit, walks
// the keys, reads the current key and the next one (wrapping to key 0) through
// the single read port of the key memory, then runs one blend of 10 byte lanes
// in the shared lerp divider, a multiply and divide steps per enabled lane,
// passing over disabled lanes; a cross-fade adds a second blend. A zero
// loop_length skips the remainder and the key blend and copies key 0.
// One item is worked on at a time; a finished result waits in the output
// register while the next item is accepted, and a stalled receiver holds the
// block only once a second result is ready.
// Config port (cfg_valid_i/cfg_ready_o) is always ready; write only when idle.
// Reset clears registers, held color and the per-key valid bits, so the key
// table reads as zero; there is no clearing pass.
`default_nettype none
module keyframe_color_blender import kcb_pkg::*; #(
  parameter int MAX_KEYS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_ready_o,
  input  wire in_t         in_data_i,
  output      logic        out_valid_o,
  input  wire logic        out_ready_i,
  output      out_t        out_data_o,
  input  wire logic        cfg_valid_i,
  output      logic        cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  localparam int AW  = $clog2(MAX_KEYS);
  localparam int ALW = 16 + AW + 1;
  localparam logic [AW-1:0] LastKey = AW'(MAX_KEYS - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_MOD, S_WALK_RD, S_WALK_CHK, S_CUR_RD, S_CUR_CHK, S_NXT_RD, S_NXT_CHK,
    S_B_RD, S_B_CHK, S_TGT_WAIT, S_TGT_DONE, S_FADE_WAIT, S_PUSH, S_FIN
  } state_e;

  state_e              state_q;
  logic [15:0]         loop_len_q, xfade_q, fade_q;
  logic [3:0]          mask_q;
  logic                hold_q;
  color_t              held_q, a_q, b_q, tgt_q;
  logic [MAX_KEYS-1:0] valid_q;
  logic                rd_vld_q;
  logic [31:0]         dividend_q;
  logic [15:0]         rem_q, f_q, off_q, span_cur_q;
  logic [4:0]          cnt_q;
  logic [ALW-1:0]      along_q;
  logic [AW-1:0]       k_q, addr_q, cur_q;
  logic                fade_mode_q, copy_only_q, phase2_q, lerp_start_q;
  logic                out_valid_q;
  out_t                out_q;

  logic                in_fire, we, key_ok, push;
  logic [8:0]          ki_ext;
  key_t                wkey, rdata, rkey;
  logic [16:0]         rem_n;
  logic [ALW-1:0]      span_end;
  logic                fl_fading;
  lerp_req_t           lreq;
  color_t              lerp_a, lerp_b, lerp_res;
  logic                lerp_done;

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_fire     = in_valid_i && in_ready_o;
  assign ki_ext      = 9'(in_data_i.key_index);
  assign key_ok      = ki_ext < 9'(MAX_KEYS);
  assign we          = in_fire && (in_data_i.opcode == OP_WRITE_KEY) && key_ok;
  assign wkey        = '{span: in_data_i.key_span,
                         color: '{lvl: in_data_i.key_min_level,
                                  lod: in_data_i.key_lod_fraction,
                                  env: in_data_i.key_environment,
                                  prim: in_data_i.key_primary}};

  kcb_ram #(.Width($bits(key_t)), .Depth(MAX_KEYS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (ki_ext[AW-1:0]),
    .wdata_i (wkey),
    .raddr_i (addr_q),
    .rdata_o (rdata)
  );

  // entries never written read as zero
  assign rkey = rd_vld_q ? rdata : '0;

  assign rem_n    = {rem_q, dividend_q[31]};
  assign span_end = along_q + ALW'(rkey.span);
  assign fl_fading = (fade_q != '0 || in_data_i.flag_active) && fade_q <= xfade_q
                     && xfade_q != '0;

  assign lerp_a     = phase2_q ? held_q : a_q;
  assign lerp_b     = phase2_q ? tgt_q : b_q;
  assign lreq.start = lerp_start_q;
  assign lreq.num   = phase2_q ? fade_q : off_q;
  assign lreq.den   = phase2_q ? xfade_q : span_cur_q;
  assign lreq.mask  = mask_q;

  kcb_lerp u_lerp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (lreq),
    .a_i    (lerp_a),
    .b_i    (lerp_b),
    .base_i (held_q),
    .done_o (lerp_done),
    .res_o  (lerp_res)
  );

  assign push = (state_q == S_PUSH) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      loop_len_q   <= '0;
      mask_q       <= 4'hF;
      xfade_q      <= '0;
      hold_q       <= 1'b0;
      held_q       <= '0;
      fade_q       <= '0;
      valid_q      <= '0;
      rd_vld_q     <= 1'b0;
      a_q          <= '0;
      b_q          <= '0;
      tgt_q        <= '0;
      dividend_q   <= '0;
      rem_q        <= '0;
      f_q          <= '0;
      off_q        <= '0;
      span_cur_q   <= '0;
      cnt_q        <= '0;
      along_q      <= '0;
      k_q          <= '0;
      addr_q       <= '0;
      cur_q        <= '0;
      fade_mode_q  <= 1'b0;
      copy_only_q  <= 1'b0;
      phase2_q     <= 1'b0;
      lerp_start_q <= 1'b0;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
    end else begin
      lerp_start_q <= 1'b0;
      rd_vld_q     <= valid_q[addr_q];

      if (cfg_valid_i) begin
        unique case (cfg_e'(cfg_index_i))
          CFG_LOOP_LENGTH:    loop_len_q <= cfg_data_i;
          CFG_COMPONENT_MASK: mask_q     <= cfg_data_i[3:0];
          CFG_CROSSFADE:      xfade_q    <= cfg_data_i;
          CFG_HOLD:           hold_q     <= cfg_data_i[0];
          default:            ;
        endcase
      end

      if (we) begin
        valid_q[ki_ext[AW-1:0]] <= 1'b1;
      end

      if (push) begin
        out_valid_q <= 1'b1;
        out_q <= '{out_primary: held_q.prim, out_environment: held_q.env,
                   out_lod_fraction: held_q.lod, out_min_level: held_q.lvl,
                   emit_primary: mask_q[0], emit_environment: mask_q[1]};
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            fade_mode_q <= 1'b0;
            phase2_q    <= 1'b0;
            copy_only_q <= (loop_len_q == '0);
            dividend_q  <= in_data_i.frame;
            rem_q       <= '0;
            cnt_q       <= '0;
            cur_q       <= '0;
            addr_q      <= '0;
            unique case (in_data_i.opcode)
              OP_FRAME: begin
                state_q <= (loop_len_q == '0) ? S_CUR_RD : S_MOD;
              end
              OP_FLAGGED: begin
                if (!in_data_i.flag_active && fade_q == '0 && !hold_q) begin
                  state_q <= S_FIN;
                end else if (fl_fading) begin
                  fade_mode_q <= 1'b1;
                  if (in_data_i.flag_active) begin
                    if (fade_q < xfade_q) fade_q <= fade_q + 16'd1;
                  end else if (fade_q != '0) begin
                    fade_q <= fade_q - 16'd1;
                  end
                  state_q <= (loop_len_q == '0) ? S_CUR_RD : S_MOD;
                end else if (in_data_i.flag_active) begin
                  state_q <= (loop_len_q == '0) ? S_CUR_RD : S_MOD;
                end else begin
                  state_q <= S_PUSH;
                end
              end
              default: state_q <= S_FIN;
            endcase
          end
        end
        S_MOD: begin
          dividend_q <= {dividend_q[30:0], 1'b0};
          cnt_q      <= cnt_q + 5'd1;
          if (rem_n >= {1'b0, loop_len_q}) begin
            rem_q <= 16'(rem_n - {1'b0, loop_len_q});
          end else begin
            rem_q <= rem_n[15:0];
          end
          if (cnt_q == 5'd31) begin
            f_q     <= (rem_n >= {1'b0, loop_len_q}) ?
                       16'(rem_n - {1'b0, loop_len_q}) : rem_n[15:0];
            along_q <= '0;
            k_q     <= '0;
            addr_q  <= '0;
            state_q <= S_WALK_RD;
          end
        end
        S_WALK_RD: state_q <= S_WALK_CHK;
        S_WALK_CHK: begin
          if (rkey.span == '0) begin
            cur_q   <= '0;
            off_q   <= '0;
            addr_q  <= '0;
            state_q <= S_CUR_RD;
          end else if (ALW'(f_q) <= span_end) begin
            cur_q   <= k_q;
            off_q   <= f_q - along_q[15:0];
            addr_q  <= k_q;
            state_q <= S_CUR_RD;
          end else if (k_q == LastKey) begin
            cur_q   <= '0;
            off_q   <= '0;
            addr_q  <= '0;
            state_q <= S_CUR_RD;
          end else begin
            along_q <= span_end;
            k_q     <= k_q + AW'(1);
            addr_q  <= k_q + AW'(1);
            state_q <= S_WALK_RD;
          end
        end
        S_CUR_RD: state_q <= S_CUR_CHK;
        S_CUR_CHK: begin
          a_q        <= rkey.color;
          span_cur_q <= rkey.span;
          if (copy_only_q || rkey.span == '0) begin
            tgt_q   <= rkey.color;
            state_q <= S_TGT_DONE;
          end else if (cur_q == LastKey) begin
            addr_q  <= '0;
            state_q <= S_B_RD;
          end else begin
            addr_q  <= cur_q + AW'(1);
            state_q <= S_NXT_RD;
          end
        end
        S_NXT_RD: state_q <= S_NXT_CHK;
        S_NXT_CHK: begin
          if (rkey.span != '0) begin
            b_q          <= rkey.color;
            lerp_start_q <= 1'b1;
            state_q      <= S_TGT_WAIT;
          end else if (cur_q == '0) begin
            // wraps back onto itself: plain copy of the current key
            tgt_q   <= a_q;
            state_q <= S_TGT_DONE;
          end else begin
            addr_q  <= '0;
            state_q <= S_B_RD;
          end
        end
        S_B_RD: state_q <= S_B_CHK;
        S_B_CHK: begin
          b_q          <= rkey.color;
          lerp_start_q <= 1'b1;
          state_q      <= S_TGT_WAIT;
        end
        S_TGT_WAIT: begin
          if (lerp_done) begin
            tgt_q   <= lerp_res;
            state_q <= S_TGT_DONE;
          end
        end
        S_TGT_DONE: begin
          if (fade_mode_q) begin
            phase2_q     <= 1'b1;
            lerp_start_q <= 1'b1;
            state_q      <= S_FADE_WAIT;
          end else begin
            held_q  <= tgt_q;
            state_q <= S_PUSH;
          end
        end
        S_FADE_WAIT: begin
          if (lerp_done) begin
            held_q  <= lerp_res;
            state_q <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (push) state_q <= S_IDLE;
        end
        S_FIN: state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

FILE: src/kcb_checker.sv
`default_nettype none
module kcb_checker import kcb_pkg::*; (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_o,
  input wire logic out_valid_o,
  input wire logic out_ready_i,
  input wire out_t out_data_o
);

  // every accepted item leaves the block busy in the cycle after it is accepted
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while previous item still in work");

  // a new result beat comes only out of a busy cycle
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without an item in work");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result beat dropped or changed");

endmodule

bind keyframe_color_blender kcb_checker u_kcb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
`default_nettype wire
